// ===== rtl/rlpkc_pkg.sv =====
package rlpkc_pkg;

    localparam int MAX_KEY_LENGTH = 8;
    localparam int KEY_IDX_W      = $clog2(MAX_KEY_LENGTH);
    localparam int KEY_LEN_W      = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MONTH = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;

    localparam logic [2:0] FIELD_FILE  = 3'd0;
    localparam logic [2:0] FIELD_LINE  = 3'd1;
    localparam logic [2:0] FIELD_MONTH = 3'd2;
    localparam logic [2:0] FIELD_DAY   = 3'd3;
    localparam logic [2:0] FIELD_TEXT  = 3'd4;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h6E614A, 24'h626546, 24'h72614D, 24'h727041,
        24'h79614D, 24'h6E754A, 24'h6C754A, 24'h677541,
        24'h706553, 24'h74634F, 24'h766F4E, 24'h636544
    };

    typedef struct packed {
        logic text_shift;
        logic record_clear;
    } t_win_ctl;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] file_number;
        logic signed [31:0] line_number;
        logic [3:0]         month;
        logic signed [7:0]  day;
        logic [7:0]         hit_count;
    } t_result;

    function automatic logic [3:0] match_month(input logic [23:0] letters,
                                               input logic [1:0] count);
        logic [3:0] m;
        m = 4'd0;
        if (count == 2'd3) begin
            for (int i = 11; i >= 0; i--) begin
                if (letters == MONTH_NAMES[i]) begin
                    m = 4'(i + 1);
                end
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/record_line_parser_keyword_count.sv =====
// Record line parser with keyword hit counter.
// Input channel: one character per transaction on i_in_valid / o_in_ready,
// byte in i_char_byte. A record is "file line Mon day text" ending in a
// newline; only the newline produces a result transaction.
// Output channel: o_out_valid / i_out_ready with status, file number, line
// number, month, day and hit count, held in an output register.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 key bytes, 1 key length); write only between records.
// Throughput: one character per cycle unless stalled. The text window is a chain of eight
// byte cells, each comparing its incoming byte against its key byte, so the
// key compare and hit count update settle in the same cycle as the shift.
// Result: registered; it appears in the cycle after the newline is accepted.
// Stall: while a result waits and i_out_ready is low, o_in_ready is low;
// when the result is taken the next character is accepted in the same cycle.
// Reset: synchronous, active low; clears parser state, empties the output
// register, key bytes to zero and key length to one.
module record_line_parser_keyword_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_char_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic signed [15:0]               o_file_number,
    output logic signed [31:0]               o_line_number,
    output logic [3:0]                       o_month,
    output logic signed [7:0]                o_day,
    output logic [7:0]                       o_hit_count,
    input  logic                             i_cfg_we,
    input  logic [rlpkc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlpkc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int N = rlpkc_pkg::MAX_KEY_LENGTH;

    logic [8*N-1:0]                    r_key_bytes;
    logic [rlpkc_pkg::KEY_LEN_W-1:0]   r_key_length;
    logic                              r_out_valid;
    rlpkc_pkg::t_result                r_result;

    logic                              in_accept;
    logic [rlpkc_pkg::KEY_LEN_W-1:0]   eff_len;
    logic [7:0]                        cell_byte  [N];
    logic                              cell_valid [N];
    logic                              cell_match [N];
    logic [7:0]                        key_sel    [N];
    logic                              key_active [N];
    logic [rlpkc_pkg::KEY_LEN_W-1:0]   key_diff   [N];
    logic                              hit;
    rlpkc_pkg::t_win_ctl               win_ctl;
    logic                              res_valid;
    rlpkc_pkg::t_result                res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= '0;
            r_key_length <= rlpkc_pkg::KEY_LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == rlpkc_pkg::CFG_KEY_BYTES) begin
                r_key_bytes <= i_cfg_data[8*N-1:0];
            end else if (i_cfg_index == rlpkc_pkg::CFG_KEY_LENGTH) begin
                r_key_length <= i_cfg_data[rlpkc_pkg::KEY_LEN_W-1:0];
            end
        end
    end

    assign eff_len = (r_key_length > rlpkc_pkg::KEY_LEN_W'(N)) ?
                     rlpkc_pkg::KEY_LEN_W'(N) : r_key_length;

    // cell k takes in the byte k positions back; it compares against key byte len-1-k
    always_comb begin
        for (int k = 0; k < N; k++) begin
            key_active[k] = (rlpkc_pkg::KEY_LEN_W'(k) < eff_len);
            key_diff[k]   = eff_len - rlpkc_pkg::KEY_LEN_W'(k) - rlpkc_pkg::KEY_LEN_W'(1);
            key_sel[k]    = r_key_bytes[8*key_diff[k][rlpkc_pkg::KEY_IDX_W-1:0] +: 8];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [7:0] d_byte;
        logic       d_valid;
        if (k == 0) begin : g_head
            assign d_byte  = i_char_byte;
            assign d_valid = 1'b1;
        end else begin : g_body
            assign d_byte  = cell_byte[k-1];
            assign d_valid = cell_valid[k-1];
        end
        rlpkc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (win_ctl.text_shift),
            .i_clear    (win_ctl.record_clear),
            .i_byte     (d_byte),
            .i_valid    (d_valid),
            .i_key_byte (key_sel[k]),
            .i_active   (key_active[k]),
            .o_byte     (cell_byte[k]),
            .o_valid    (cell_valid[k]),
            .o_match    (cell_match[k])
        );
    end

    always_comb begin
        hit = (eff_len != '0);
        for (int k = 0; k < N; k++) begin
            hit = hit && cell_match[k];
        end
    end

    rlpkc_field u_field (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_char_byte    (i_char_byte),
        .i_hit          (hit),
        .o_ctl          (win_ctl),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_file_number = r_result.file_number;
    assign o_line_number = r_result.line_number;
    assign o_month       = r_result.month;
    assign o_day         = r_result.day;
    assign o_hit_count   = r_result.hit_count;

endmodule

// ===== rtl/rlpkc_cell.sv =====
module rlpkc_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    input  logic [7:0] i_key_byte,
    input  logic       i_active,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output logic       o_match
);

    logic [7:0] r_byte;
    logic       r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // match on the byte this cell takes in the current shift
    assign o_match = !i_active || (i_valid && (i_byte == i_key_byte));
    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// ===== rtl/rlpkc_field.sv =====
module rlpkc_field (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_hit,
    output rlpkc_pkg::t_win_ctl  o_ctl,
    output logic                 o_result_valid,
    output rlpkc_pkg::t_result   o_result
);

    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_stopped, n_stopped;
    logic        r_started, n_started;
    logic [23:0] r_letters, n_letters;
    logic [1:0]  r_letter_cnt, n_letter_cnt;
    logic [15:0] r_file, n_file;
    logic [31:0] r_line, n_line;
    logic [3:0]  r_month, n_month;
    logic [7:0]  r_day, n_day;
    logic [7:0]  r_hits, n_hits;

    logic [31:0] value;
    logic        is_newline;
    logic        is_space;
    logic        is_digit;
    logic        complete;

    assign value      = r_neg ? (32'd0 - r_acc) : r_acc;
    assign is_newline = (i_char_byte == rlpkc_pkg::CHAR_NEWLINE);
    assign is_space   = (i_char_byte == rlpkc_pkg::CHAR_SPACE);
    assign is_digit   = (i_char_byte >= rlpkc_pkg::CHAR_ZERO) &&
                        (i_char_byte <= rlpkc_pkg::CHAR_NINE);
    assign complete   = (r_pos >= rlpkc_pkg::FIELD_TEXT);

    always_comb begin
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_stopped    = r_stopped;
        n_started    = r_started;
        n_letters    = r_letters;
        n_letter_cnt = r_letter_cnt;
        n_file       = r_file;
        n_line       = r_line;
        n_month      = r_month;
        n_day        = r_day;
        n_hits       = r_hits;
        o_ctl        = '0;

        o_result_valid       = i_accept && is_newline;
        o_result.status      = !complete ? rlpkc_pkg::STATUS_SHORT :
                               (r_month == 4'd0 ? rlpkc_pkg::STATUS_BAD_MONTH
                                                : rlpkc_pkg::STATUS_OK);
        o_result.file_number = r_file;
        o_result.line_number = r_line;
        o_result.month       = r_month;
        o_result.day         = complete ? r_day : 8'd0;
        o_result.hit_count   = complete ? r_hits : 8'd0;

        if (i_accept) begin
            if (is_newline) begin
                o_ctl.record_clear = 1'b1;
                n_pos        = rlpkc_pkg::FIELD_FILE;
                n_acc        = '0;
                n_neg        = 1'b0;
                n_stopped    = 1'b0;
                n_started    = 1'b0;
                n_letters    = '0;
                n_letter_cnt = '0;
                n_file       = '0;
                n_line       = '0;
                n_month      = '0;
                n_day        = '0;
                n_hits       = '0;
            end else if (complete) begin
                o_ctl.text_shift = 1'b1;
                if (i_hit) begin
                    n_hits = r_hits + 8'd1;
                end
            end else if (r_pos == rlpkc_pkg::FIELD_MONTH) begin
                if (is_space) begin
                    n_month      = rlpkc_pkg::match_month(r_letters, r_letter_cnt);
                    n_letters    = '0;
                    n_letter_cnt = '0;
                    n_pos        = rlpkc_pkg::FIELD_DAY;
                end else if (r_letter_cnt != 2'd3) begin
                    unique case (r_letter_cnt)
                        2'd0:    n_letters[7:0]   = i_char_byte;
                        2'd1:    n_letters[15:8]  = i_char_byte;
                        default: n_letters[23:16] = i_char_byte;
                    endcase
                    n_letter_cnt = r_letter_cnt + 2'd1;
                end
            end else begin
                if (is_space) begin
                    if (r_pos == rlpkc_pkg::FIELD_FILE) begin
                        n_file = value[15:0];
                    end else if (r_pos == rlpkc_pkg::FIELD_LINE) begin
                        n_line = value;
                    end else begin
                        n_day = value[7:0];
                    end
                    n_acc     = '0;
                    n_neg     = 1'b0;
                    n_stopped = 1'b0;
                    n_started = 1'b0;
                    n_pos     = r_pos + 3'd1;
                end else begin
                    if (!r_started && (i_char_byte == rlpkc_pkg::CHAR_PLUS ||
                                       i_char_byte == rlpkc_pkg::CHAR_MINUS)) begin
                        n_neg = (i_char_byte == rlpkc_pkg::CHAR_MINUS);
                    end else if (!r_stopped && is_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) +
                                {24'd0, i_char_byte - rlpkc_pkg::CHAR_ZERO};
                    end else begin
                        n_stopped = 1'b1;
                    end
                    n_started = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= rlpkc_pkg::FIELD_FILE;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_stopped    <= 1'b0;
            r_started    <= 1'b0;
            r_letters    <= '0;
            r_letter_cnt <= '0;
            r_file       <= '0;
            r_line       <= '0;
            r_month      <= '0;
            r_day        <= '0;
            r_hits       <= '0;
        end else begin
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_neg        <= n_neg;
            r_stopped    <= n_stopped;
            r_started    <= n_started;
            r_letters    <= n_letters;
            r_letter_cnt <= n_letter_cnt;
            r_file       <= n_file;
            r_line       <= n_line;
            r_month      <= n_month;
            r_day        <= n_day;
            r_hits       <= n_hits;
        end
    end

endmodule
